### hw/rtl/ucd_pkg.sv
// Shared constants, types and tables for the seconds-to-civil-date pipeline.
package ucd_pkg;

  // Port field widths.
  localparam int unsigned SEC_W    = 40;
  localparam int unsigned YEAR_W   = 16;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned HOUR_W   = 5;
  localparam int unsigned MIN_W    = 6;
  localparam int unsigned SECOND_W = 6;

  // Pipeline depth: the day split takes the first stages, the rest is date and time of day.
  localparam int unsigned NSTG      = 13;
  localparam int unsigned SPLIT_STG = 4;
  localparam int unsigned BACK_STG  = NSTG - SPLIT_STG;
  localparam int unsigned TOD_CALC  = 4;
  localparam int unsigned TOD_PAD   = BACK_STG - TOD_CALC;

  // Seconds per day is 128 * 675: shift by 7, then divide by 675 in two chunks.
  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DAY_ODD   = 675;
  localparam int unsigned XL_W      = 16;
  localparam int unsigned XH_W      = SEC_W - DAY_SHIFT - XL_W;
  localparam int unsigned QH_W      = 8;
  localparam int unsigned QL_W      = XL_W;
  localparam int unsigned REM_W     = $clog2(DAY_ODD);
  localparam int unsigned Y_W       = REM_W + XL_W;
  localparam int unsigned SOD_W     = REM_W + DAY_SHIFT;
  localparam int unsigned Z_W       = QH_W + QL_W;
  localparam int unsigned SHIFT_DAYS = 719468;

  // Reciprocal for the high chunk divide by 675.
  localparam int unsigned    DH_K  = XH_W + $clog2(DAY_ODD);
  localparam longint unsigned DH_M = ((64'd1 << DH_K) + DAY_ODD - 1) / DAY_ODD;
  localparam int unsigned    DH_MW = $clog2(DH_M + 1);

  // Reciprocal for the low chunk divide by 675.
  localparam int unsigned    DL_K  = Y_W + $clog2(DAY_ODD);
  localparam longint unsigned DL_M = ((64'd1 << DL_K) + DAY_ODD - 1) / DAY_ODD;
  localparam int unsigned    DL_MW = $clog2(DL_M + 1);

  // Era split of the shifted day count.
  localparam int unsigned    ERA_DAYS = 146097;
  localparam int unsigned    ERA_LAST = 146096;
  localparam int unsigned    ERA_W    = 7;
  localparam int unsigned    DOE_W    = $clog2(ERA_DAYS);
  localparam int unsigned    ERA_K    = Z_W + $clog2(ERA_DAYS);
  localparam longint unsigned ERA_M   = ((64'd1 << ERA_K) + ERA_DAYS - 1) / ERA_DAYS;
  localparam int unsigned    ERA_MW   = $clog2(ERA_M + 1);
  localparam int unsigned    YEARS_PER_ERA = 400;

  // Leap corrections inside an era.
  localparam int unsigned    QUAD_DAYS = 1460;
  localparam int unsigned    CENT_DAYS = 36524;
  localparam int unsigned    A_W       = 7;
  localparam int unsigned    B_W       = 3;
  localparam int unsigned    A_K       = DOE_W + $clog2(QUAD_DAYS);
  localparam longint unsigned A_M      = ((64'd1 << A_K) + QUAD_DAYS - 1) / QUAD_DAYS;
  localparam int unsigned    A_MW      = $clog2(A_M + 1);
  localparam int unsigned    B_K       = DOE_W + $clog2(CENT_DAYS);
  localparam longint unsigned B_M      = ((64'd1 << B_K) + CENT_DAYS - 1) / CENT_DAYS;
  localparam int unsigned    B_MW      = $clog2(B_M + 1);

  // Year of era and day of year.
  localparam int unsigned    YEAR_DAYS = 365;
  localparam int unsigned    YOE_W     = 9;
  localparam int unsigned    YOE_K     = DOE_W + $clog2(YEAR_DAYS);
  localparam longint unsigned YOE_M    = ((64'd1 << YOE_K) + YEAR_DAYS - 1) / YEAR_DAYS;
  localparam int unsigned    YOE_MW    = $clog2(YOE_M + 1);
  localparam int unsigned    CENTURY   = 100;
  localparam int unsigned    C_W       = 3;
  localparam int unsigned    C_K       = YOE_W + $clog2(CENTURY);
  localparam longint unsigned C_M      = ((64'd1 << C_K) + CENTURY - 1) / CENTURY;
  localparam int unsigned    C_MW      = $clog2(C_M + 1);
  localparam int unsigned    DOY_W     = 9;

  // March-based month.
  localparam int unsigned    MP_DIV = 153;
  localparam int unsigned    MPV_W  = 11;
  localparam int unsigned    MP_W   = 4;
  localparam int unsigned    MP_K   = MPV_W + $clog2(MP_DIV);
  localparam longint unsigned MP_M  = ((64'd1 << MP_K) + MP_DIV - 1) / MP_DIV;
  localparam int unsigned    MP_MW  = $clog2(MP_M + 1);
  localparam int unsigned    MP_JAN = 10;

  // Time of day.
  localparam int unsigned    HOUR_SECS = 3600;
  localparam int unsigned    HR_K      = SOD_W + $clog2(HOUR_SECS);
  localparam longint unsigned HR_M     = ((64'd1 << HR_K) + HOUR_SECS - 1) / HOUR_SECS;
  localparam int unsigned    HR_MW     = $clog2(HR_M + 1);
  localparam int unsigned    REMH_W    = $clog2(HOUR_SECS);
  localparam int unsigned    MIN_SECS  = 60;
  localparam int unsigned    MN_K      = REMH_W + $clog2(MIN_SECS);
  localparam longint unsigned MN_M     = ((64'd1 << MN_K) + MIN_SECS - 1) / MIN_SECS;
  localparam int unsigned    MN_MW     = $clog2(MN_M + 1);

  // Time of day fields as they travel together down the pipe.
  typedef struct packed {
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [SECOND_W-1:0] second;
  } ucd_tod_t;

  // Day of year at which each March-based month starts.
  function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
    logic [DOY_W-1:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

endpackage

### hw/rtl/unix_seconds_to_civil_datetime.sv
// Top level: pipelined Unix seconds to Gregorian date and time of day converter.
// Every item passes through all 13 pipeline stages on its way to out_valid.
// Throughput: one item per cycle while in_ready is high.
// Stalls collapse bubbles stage by stage, so in_ready drops only while every stage is full
// and out_ready is low.
// Reset (rst_n low, synchronous) clears only the stage valid bits; data registers keep contents.
module unix_seconds_to_civil_datetime (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [ucd_pkg::SEC_W-1:0]      in_epoch_seconds,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [ucd_pkg::YEAR_W-1:0]     out_year,
  output logic [ucd_pkg::MONTH_W-1:0]    out_month,
  output logic [ucd_pkg::DAY_W-1:0]      out_day,
  output logic [ucd_pkg::HOUR_W-1:0]     out_hour,
  output logic [ucd_pkg::MIN_W-1:0]      out_minute,
  output logic [ucd_pkg::SECOND_W-1:0]   out_second
);

  logic [ucd_pkg::NSTG-1:0]  v_r;
  logic [ucd_pkg::NSTG-1:0]  v_nxt;
  logic [ucd_pkg::NSTG-1:0]  stg_en;
  logic [ucd_pkg::Z_W-1:0]   z;
  logic [ucd_pkg::SOD_W-1:0] sod;
  ucd_pkg::ucd_tod_t         tod;

  // A stage may load when it is empty or the stage after it loads too.
  always_comb begin
    stg_en[ucd_pkg::NSTG-1] = !v_r[ucd_pkg::NSTG-1] || out_ready;
    for (int i = int'(ucd_pkg::NSTG) - 2; i >= 0; i--) begin
      stg_en[i] = !v_r[i] || stg_en[i+1];
    end
  end

  // Valid bits move with the data.
  always_comb begin
    for (int i = 0; i < int'(ucd_pkg::NSTG); i++) begin
      if (stg_en[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = stg_en[0];
  assign out_valid = v_r[ucd_pkg::NSTG-1];

  // Day count and seconds of day.
  ucd_daysplit u_split (
    .clk           (clk),
    .en            (stg_en[ucd_pkg::SPLIT_STG-1:0]),
    .epoch_seconds (in_epoch_seconds),
    .z             (z),
    .sod           (sod)
  );

  // Hour, minute and second.
  ucd_tod u_tod (
    .clk (clk),
    .en  (stg_en[ucd_pkg::NSTG-1:ucd_pkg::SPLIT_STG]),
    .sod (sod),
    .tod (tod)
  );

  // Year, month and day.
  ucd_civil u_civil (
    .clk   (clk),
    .en    (stg_en[ucd_pkg::NSTG-1:ucd_pkg::SPLIT_STG]),
    .z     (z),
    .year  (out_year),
    .month (out_month),
    .day   (out_day)
  );

  assign out_hour   = tod.hour;
  assign out_minute = tod.minute;
  assign out_second = tod.second;

`ifndef SYNTHESIS
  // The input side only stalls when every stage holds an item.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r))
    else $error("input stalled while a pipeline stage was empty");

  // An item in the next-to-last stage reaches the output when the sink takes.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready && v_r[ucd_pkg::NSTG-2] |=> out_valid)
    else $error("item did not advance into the output stage");

  // Calendar fields stay in range.
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1) && (out_month <= 4'd12)
                  && (out_day >= 5'd1) && (out_day <= 5'd31))
    else $error("month or day out of range");

  // Time of day fields stay in range.
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23) && (out_minute <= 6'd59) && (out_second <= 6'd59))
    else $error("hour, minute or second out of range");
`endif

endmodule

### hw/rtl/ucd_daysplit.sv
// Splits seconds into a shifted day count and seconds of day over four stages.
module ucd_daysplit (
  input  logic                           clk,
  input  logic [ucd_pkg::SPLIT_STG-1:0]  en,
  input  logic [ucd_pkg::SEC_W-1:0]      epoch_seconds,
  output logic [ucd_pkg::Z_W-1:0]        z,
  output logic [ucd_pkg::SOD_W-1:0]      sod
);

  localparam int unsigned QH_PW = ucd_pkg::XH_W + ucd_pkg::DH_MW;
  localparam int unsigned QL_PW = ucd_pkg::Y_W + ucd_pkg::DL_MW;

  // Stage 0: quotient of the high chunk by 675.
  logic [ucd_pkg::XH_W-1:0]      xh;
  logic [QH_PW-1:0]              qh_prod;
  logic [ucd_pkg::QH_W-1:0]      qh_nxt;
  logic [ucd_pkg::SEC_W-1:0]     t0_r;
  logic [ucd_pkg::QH_W-1:0]      qh0_r;

  assign xh      = epoch_seconds[ucd_pkg::SEC_W-1 -: ucd_pkg::XH_W];
  assign qh_prod = QH_PW'(xh) * QH_PW'(ucd_pkg::DH_M);
  assign qh_nxt  = ucd_pkg::QH_W'(qh_prod >> ucd_pkg::DH_K);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      t0_r  <= epoch_seconds;
      qh0_r <= qh_nxt;
    end
  end

  // Stage 1: remainder of the high chunk joins the low chunk.
  logic [ucd_pkg::REM_W-1:0]     rh_nxt;
  logic [ucd_pkg::Y_W-1:0]       y1_r;
  logic [ucd_pkg::QH_W-1:0]      qh1_r;
  logic [ucd_pkg::DAY_SHIFT-1:0] tlo1_r;

  assign rh_nxt = ucd_pkg::REM_W'(t0_r[ucd_pkg::SEC_W-1 -: ucd_pkg::XH_W]
                  - ucd_pkg::XH_W'(qh0_r) * ucd_pkg::XH_W'(ucd_pkg::DAY_ODD));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      y1_r   <= {rh_nxt, t0_r[ucd_pkg::DAY_SHIFT +: ucd_pkg::XL_W]};
      qh1_r  <= qh0_r;
      tlo1_r <= t0_r[ucd_pkg::DAY_SHIFT-1:0];
    end
  end

  // Stage 2: quotient of the combined low chunk by 675.
  logic [QL_PW-1:0]              ql_prod;
  logic [ucd_pkg::QL_W-1:0]      ql_nxt;
  logic [ucd_pkg::Y_W-1:0]       y2_r;
  logic [ucd_pkg::QH_W-1:0]      qh2_r;
  logic [ucd_pkg::QL_W-1:0]      ql2_r;
  logic [ucd_pkg::DAY_SHIFT-1:0] tlo2_r;

  assign ql_prod = QL_PW'(y1_r) * QL_PW'(ucd_pkg::DL_M);
  assign ql_nxt  = ucd_pkg::QL_W'(ql_prod >> ucd_pkg::DL_K);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      y2_r   <= y1_r;
      qh2_r  <= qh1_r;
      ql2_r  <= ql_nxt;
      tlo2_r <= tlo1_r;
    end
  end

  // Stage 3: seconds of day from the remainder, day count moved to the March epoch.
  logic [ucd_pkg::REM_W-1:0] rl_nxt;
  logic [ucd_pkg::Z_W-1:0]   z_nxt;
  logic [ucd_pkg::Z_W-1:0]   z_r;
  logic [ucd_pkg::SOD_W-1:0] sod_r;

  assign rl_nxt = ucd_pkg::REM_W'(y2_r
                  - ucd_pkg::Y_W'(ql2_r) * ucd_pkg::Y_W'(ucd_pkg::DAY_ODD));
  assign z_nxt  = {qh2_r, ql2_r} + ucd_pkg::Z_W'(ucd_pkg::SHIFT_DAYS);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      z_r   <= z_nxt;
      sod_r <= {rl_nxt, tlo2_r};
    end
  end

  assign z   = z_r;
  assign sod = sod_r;

endmodule

### hw/rtl/ucd_tod.sv
// Splits seconds of day into hour, minute and second and aligns them to the date.
module ucd_tod (
  input  logic                          clk,
  input  logic [ucd_pkg::BACK_STG-1:0]  en,
  input  logic [ucd_pkg::SOD_W-1:0]     sod,
  output ucd_pkg::ucd_tod_t             tod
);

  localparam int unsigned HR_PW = ucd_pkg::SOD_W + ucd_pkg::HR_MW;
  localparam int unsigned MN_PW = ucd_pkg::REMH_W + ucd_pkg::MN_MW;

  // First stage: hour by reciprocal multiply.
  logic [HR_PW-1:0]            hr_prod;
  logic [ucd_pkg::HOUR_W-1:0]  hr_nxt;
  logic [ucd_pkg::SOD_W-1:0]   sod0_r;
  logic [ucd_pkg::HOUR_W-1:0]  hr0_r;

  assign hr_prod = HR_PW'(sod) * HR_PW'(ucd_pkg::HR_M);
  assign hr_nxt  = ucd_pkg::HOUR_W'(hr_prod >> ucd_pkg::HR_K);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sod0_r <= sod;
      hr0_r  <= hr_nxt;
    end
  end

  // Second stage: seconds left within the hour.
  logic [ucd_pkg::REMH_W-1:0]  remh_nxt;
  logic [ucd_pkg::REMH_W-1:0]  remh1_r;
  logic [ucd_pkg::HOUR_W-1:0]  hr1_r;

  assign remh_nxt = ucd_pkg::REMH_W'(sod0_r
                    - ucd_pkg::SOD_W'(hr0_r) * ucd_pkg::SOD_W'(ucd_pkg::HOUR_SECS));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      remh1_r <= remh_nxt;
      hr1_r   <= hr0_r;
    end
  end

  // Third stage: minute by reciprocal multiply.
  logic [MN_PW-1:0]            mn_prod;
  logic [ucd_pkg::MIN_W-1:0]   mn_nxt;
  logic [ucd_pkg::REMH_W-1:0]  remh2_r;
  logic [ucd_pkg::HOUR_W-1:0]  hr2_r;
  logic [ucd_pkg::MIN_W-1:0]   mn2_r;

  assign mn_prod = MN_PW'(remh1_r) * MN_PW'(ucd_pkg::MN_M);
  assign mn_nxt  = ucd_pkg::MIN_W'(mn_prod >> ucd_pkg::MN_K);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      remh2_r <= remh1_r;
      hr2_r   <= hr1_r;
      mn2_r   <= mn_nxt;
    end
  end

  // Fourth stage: second of minute, fields packed together.
  logic [ucd_pkg::SECOND_W-1:0] sc_nxt;
  ucd_pkg::ucd_tod_t            tod3_r;

  assign sc_nxt = ucd_pkg::SECOND_W'(remh2_r
                  - ucd_pkg::REMH_W'(mn2_r) * ucd_pkg::REMH_W'(ucd_pkg::MIN_SECS));

  always_ff @(posedge clk) begin
    if (en[3]) begin
      tod3_r.hour   <= hr2_r;
      tod3_r.minute <= mn2_r;
      tod3_r.second <= sc_nxt;
    end
  end

  // Delay line that keeps the time of day in step with the date stages.
  ucd_pkg::ucd_tod_t pad_r [ucd_pkg::TOD_PAD];

  always_ff @(posedge clk) begin
    for (int i = 0; i < int'(ucd_pkg::TOD_PAD); i++) begin
      if (en[ucd_pkg::TOD_CALC + i]) begin
        pad_r[i] <= (i == 0) ? tod3_r : pad_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  assign tod = pad_r[ucd_pkg::TOD_PAD-1];

endmodule

### hw/rtl/ucd_civil.sv
// Turns the March-based day count into year, month and day over nine stages.
module ucd_civil (
  input  logic                           clk,
  input  logic [ucd_pkg::BACK_STG-1:0]   en,
  input  logic [ucd_pkg::Z_W-1:0]        z,
  output logic [ucd_pkg::YEAR_W-1:0]     year,
  output logic [ucd_pkg::MONTH_W-1:0]    month,
  output logic [ucd_pkg::DAY_W-1:0]      day
);

  localparam int unsigned ERA_PW = ucd_pkg::Z_W + ucd_pkg::ERA_MW;
  localparam int unsigned A_PW   = ucd_pkg::DOE_W + ucd_pkg::A_MW;
  localparam int unsigned B_PW   = ucd_pkg::DOE_W + ucd_pkg::B_MW;
  localparam int unsigned YOE_PW = ucd_pkg::DOE_W + ucd_pkg::YOE_MW;
  localparam int unsigned C_PW   = ucd_pkg::YOE_W + ucd_pkg::C_MW;
  localparam int unsigned MP_PW  = ucd_pkg::MPV_W + ucd_pkg::MP_MW;

  // Stage 0: era number.
  logic [ERA_PW-1:0]          era_prod;
  logic [ucd_pkg::ERA_W-1:0]  era_nxt;
  logic [ucd_pkg::Z_W-1:0]    z0_r;
  logic [ucd_pkg::ERA_W-1:0]  era0_r;

  assign era_prod = ERA_PW'(z) * ERA_PW'(ucd_pkg::ERA_M);
  assign era_nxt  = ucd_pkg::ERA_W'(era_prod >> ucd_pkg::ERA_K);

  always_ff @(posedge clk) begin
    if (en[0]) begin
      z0_r   <= z;
      era0_r <= era_nxt;
    end
  end

  // Stage 1: day of era.
  logic [ucd_pkg::DOE_W-1:0]  doe_nxt;
  logic [ucd_pkg::DOE_W-1:0]  doe1_r;
  logic [ucd_pkg::ERA_W-1:0]  era1_r;

  assign doe_nxt = ucd_pkg::DOE_W'(z0_r
                   - ucd_pkg::Z_W'(era0_r) * ucd_pkg::Z_W'(ucd_pkg::ERA_DAYS));

  always_ff @(posedge clk) begin
    if (en[1]) begin
      doe1_r <= doe_nxt;
      era1_r <= era0_r;
    end
  end

  // Stage 2: leap corrections for four-year, century and era boundaries.
  logic [A_PW-1:0]            a_prod;
  logic [B_PW-1:0]            b_prod;
  logic [ucd_pkg::DOE_W-1:0]  doe2_r;
  logic [ucd_pkg::ERA_W-1:0]  era2_r;
  logic [ucd_pkg::A_W-1:0]    a2_r;
  logic [ucd_pkg::B_W-1:0]    b2_r;
  logic                       c2_r;

  assign a_prod = A_PW'(doe1_r) * A_PW'(ucd_pkg::A_M);
  assign b_prod = B_PW'(doe1_r) * B_PW'(ucd_pkg::B_M);

  always_ff @(posedge clk) begin
    if (en[2]) begin
      doe2_r <= doe1_r;
      era2_r <= era1_r;
      a2_r   <= ucd_pkg::A_W'(a_prod >> ucd_pkg::A_K);
      b2_r   <= ucd_pkg::B_W'(b_prod >> ucd_pkg::B_K);
      c2_r   <= (doe1_r == ucd_pkg::DOE_W'(ucd_pkg::ERA_LAST));
    end
  end

  // Stage 3: day count with leap days removed.
  logic [ucd_pkg::DOE_W-1:0]  doe3_r;
  logic [ucd_pkg::ERA_W-1:0]  era3_r;
  logic [ucd_pkg::DOE_W-1:0]  num3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      doe3_r <= doe2_r;
      era3_r <= era2_r;
      num3_r <= doe2_r - ucd_pkg::DOE_W'(a2_r) + ucd_pkg::DOE_W'(b2_r)
                - ucd_pkg::DOE_W'(c2_r);
    end
  end

  // Stage 4: year of era.
  logic [YOE_PW-1:0]          yoe_prod;
  logic [ucd_pkg::DOE_W-1:0]  doe4_r;
  logic [ucd_pkg::ERA_W-1:0]  era4_r;
  logic [ucd_pkg::YOE_W-1:0]  yoe4_r;

  assign yoe_prod = YOE_PW'(num3_r) * YOE_PW'(ucd_pkg::YOE_M);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      doe4_r <= doe3_r;
      era4_r <= era3_r;
      yoe4_r <= ucd_pkg::YOE_W'(yoe_prod >> ucd_pkg::YOE_K);
    end
  end

  // Stage 5: days before the year, without the century correction.
  logic [C_PW-1:0]            c_prod;
  logic [ucd_pkg::DOE_W-1:0]  base_nxt;
  logic [ucd_pkg::DOE_W-1:0]  doe5_r;
  logic [ucd_pkg::ERA_W-1:0]  era5_r;
  logic [ucd_pkg::YOE_W-1:0]  yoe5_r;
  logic [ucd_pkg::DOE_W-1:0]  base5_r;
  logic [ucd_pkg::C_W-1:0]    cent5_r;

  assign c_prod   = C_PW'(yoe4_r) * C_PW'(ucd_pkg::C_M);
  assign base_nxt = ucd_pkg::DOE_W'(yoe4_r) * ucd_pkg::DOE_W'(ucd_pkg::YEAR_DAYS)
                    + ucd_pkg::DOE_W'(yoe4_r >> 2);

  always_ff @(posedge clk) begin
    if (en[5]) begin
      doe5_r  <= doe4_r;
      era5_r  <= era4_r;
      yoe5_r  <= yoe4_r;
      base5_r <= base_nxt;
      cent5_r <= ucd_pkg::C_W'(c_prod >> ucd_pkg::C_K);
    end
  end

  // Stage 6: day of year, March 1 is zero.
  logic [ucd_pkg::DOE_W-1:0]  doy_full;
  logic [ucd_pkg::ERA_W-1:0]  era6_r;
  logic [ucd_pkg::YOE_W-1:0]  yoe6_r;
  logic [ucd_pkg::DOY_W-1:0]  doy6_r;

  assign doy_full = doe5_r - base5_r + ucd_pkg::DOE_W'(cent5_r);

  always_ff @(posedge clk) begin
    if (en[6]) begin
      era6_r <= era5_r;
      yoe6_r <= yoe5_r;
      doy6_r <= ucd_pkg::DOY_W'(doy_full);
    end
  end

  // Stage 7: March-based month.
  logic [ucd_pkg::MPV_W-1:0]  mpv;
  logic [MP_PW-1:0]           mp_prod;
  logic [ucd_pkg::ERA_W-1:0]  era7_r;
  logic [ucd_pkg::YOE_W-1:0]  yoe7_r;
  logic [ucd_pkg::DOY_W-1:0]  doy7_r;
  logic [ucd_pkg::MP_W-1:0]   mp7_r;

  assign mpv     = ucd_pkg::MPV_W'(doy6_r) * ucd_pkg::MPV_W'(5) + ucd_pkg::MPV_W'(2);
  assign mp_prod = MP_PW'(mpv) * MP_PW'(ucd_pkg::MP_M);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      era7_r <= era6_r;
      yoe7_r <= yoe6_r;
      doy7_r <= doy6_r;
      mp7_r  <= ucd_pkg::MP_W'(mp_prod >> ucd_pkg::MP_K);
    end
  end

  // Stage 8: calendar day, month and year; January and February count in the next year.
  logic                          jan_feb;
  logic [ucd_pkg::DOY_W-1:0]     day_full;
  logic [ucd_pkg::MONTH_W-1:0]   month_nxt;
  logic [ucd_pkg::YEAR_W-1:0]    year_nxt;
  logic [ucd_pkg::YEAR_W-1:0]    year_r;
  logic [ucd_pkg::MONTH_W-1:0]   month_r;
  logic [ucd_pkg::DAY_W-1:0]     day_r;

  assign jan_feb   = (mp7_r >= ucd_pkg::MP_W'(ucd_pkg::MP_JAN));
  assign day_full  = doy7_r - ucd_pkg::month_start(mp7_r) + ucd_pkg::DOY_W'(1);
  assign month_nxt = jan_feb ? ucd_pkg::MONTH_W'(mp7_r - ucd_pkg::MP_W'(9))
                             : ucd_pkg::MONTH_W'(mp7_r + ucd_pkg::MP_W'(3));
  assign year_nxt  = ucd_pkg::YEAR_W'(yoe7_r)
                     + ucd_pkg::YEAR_W'(era7_r) * ucd_pkg::YEAR_W'(ucd_pkg::YEARS_PER_ERA)
                     + ucd_pkg::YEAR_W'(jan_feb);

  always_ff @(posedge clk) begin
    if (en[8]) begin
      year_r  <= year_nxt;
      month_r <= month_nxt;
      day_r   <= ucd_pkg::DAY_W'(day_full);
    end
  end

  assign year  = year_r;
  assign month = month_r;
  assign day   = day_r;

endmodule

### dv/tb.sv
// Testbench for the seconds-to-civil-date pipeline: predictor, scoreboard and top module.
`timescale 1ns / 100ps

package civil_tb_pkg;
  import ucd_pkg::*;

  localparam longint unsigned SECS_PER_DAY  = 86400;
  localparam longint unsigned SECS_PER_HOUR = 3600;
  localparam longint unsigned SECS_PER_MIN  = 60;
  localparam longint unsigned MARCH_SHIFT   = 719468;
  localparam longint unsigned DAYS_PER_ERA  = 146097;

  // One calendar result, laid out in port order.
  typedef struct packed {
    logic [YEAR_W-1:0]   year;
    logic [MONTH_W-1:0]  month;
    logic [DAY_W-1:0]    day;
    logic [HOUR_W-1:0]   hour;
    logic [MIN_W-1:0]    minute;
    logic [SECOND_W-1:0] second;
  } civil_t;

  // Splits a second count into the Gregorian date and the time of day.
  function automatic civil_t civil_from_seconds(input logic [SEC_W-1:0] secs);
    longint unsigned t, z, era, doe, yoe, doy, mp, d, m, y;
    civil_t r;
    t   = secs;
    z   = t / SECS_PER_DAY + MARCH_SHIFT;
    era = z / DAYS_PER_ERA;
    doe = z - era * DAYS_PER_ERA;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    d   = doy - (153 * mp + 2) / 5 + 1;
    m   = (mp < 10) ? mp + 3 : mp - 9;
    y   = yoe + era * 400 + ((m <= 2) ? 1 : 0);
    r.year   = y[YEAR_W-1:0];
    r.month  = m[MONTH_W-1:0];
    r.day    = d[DAY_W-1:0];
    r.hour   = HOUR_W'((t / SECS_PER_HOUR) % 24);
    r.minute = MIN_W'((t / SECS_PER_MIN) % 60);
    r.second = SECOND_W'(t % 60);
    return r;
  endfunction

  // Holds the dates still due from the pipeline, oldest first.
  class civil_date_board;
    civil_t             due_dates[$];
    logic [SEC_W-1:0]   due_seconds[$];
    int                 mismatches = 0;

    function void note_item(input logic [SEC_W-1:0] secs);
      due_dates.push_back(civil_from_seconds(secs));
      due_seconds.push_back(secs);
    endfunction

    function int pending();
      return due_dates.size();
    endfunction

    function void check_result(input civil_t got);
      civil_t           want;
      logic [SEC_W-1:0] secs;
      if (due_dates.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result %0d-%0d-%0d %0d:%0d:%0d with nothing due",
                   got.year, got.month, got.day, got.hour, got.minute, got.second);
        return;
      end
      want = due_dates.pop_front();
      secs = due_seconds.pop_front();
      if (got.year !== want.year || got.month !== want.month || got.day !== want.day ||
          got.hour !== want.hour || got.minute !== want.minute ||
          got.second !== want.second) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch for %0d s: expected %0d-%0d-%0d %0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d",
                   secs, want.year, want.month, want.day, want.hour, want.minute,
                   want.second, got.year, got.month, got.day, got.hour, got.minute,
                   got.second);
      end
    endfunction
  endclass

endpackage

module tb;
  import ucd_pkg::*;
  import civil_tb_pkg::*;

  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          PHASE_ITEMS    = 293;
  localparam int          SETTLE_CYCLES  = 40;
  localparam logic [SEC_W-1:0] MAX_SECONDS = {SEC_W{1'b1}};

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [SEC_W-1:0]    in_epoch_seconds = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [YEAR_W-1:0]   out_year;
  logic [MONTH_W-1:0]  out_month;
  logic [DAY_W-1:0]    out_day;
  logic [HOUR_W-1:0]   out_hour;
  logic [MIN_W-1:0]    out_minute;
  logic [SECOND_W-1:0] out_second;

  int send_idle = 17;
  int recv_idle = 63;
  int cycle_count = 0;

  civil_date_board date_check = new();

  unix_seconds_to_civil_datetime uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day          (out_day),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_second       (out_second)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Runaway guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Result side: check every accepted item and stall at random.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      date_check.check_result(civil_t'({out_year, out_month, out_day,
                                        out_hour, out_minute, out_second}));
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Seconds at midnight starting a given civil date, for date boundaries.
  function automatic longint seconds_at(input int y, input int m, input int d);
    longint yy, era, yoe, mm, doy, doe;
    yy  = (m <= 2) ? y - 1 : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mm  = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mm + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return (era * 146097 + doe - 719468) * 86400;
  endfunction

  // Random second counts: full-range noise, the near future, and month edges.
  function automatic logic [SEC_W-1:0] pick_seconds();
    int     kind;
    int     y;
    longint s;
    kind = $urandom_range(9);
    if (kind <= 3)
      return {8'($urandom_range(255)), 32'($urandom())};
    if (kind <= 5)
      return {7'd0, 1'($urandom_range(1)), 32'($urandom())};
    y = ($urandom_range(1) == 0) ? $urandom_range(1970, 2500) : $urandom_range(1970, 36811);
    s = seconds_at(y, $urandom_range(1, 12), 1);
    if ($urandom_range(1) == 0)
      s = s + $urandom_range(0, 2) - 1;
    else
      s = s + longint'($urandom_range(0, 4 * 86400)) - 2 * 86400;
    if (s < 0)
      s = 0;
    if (s > longint'(MAX_SECONDS))
      s = longint'(MAX_SECONDS) - $urandom_range(0, 86400);
    return s[SEC_W-1:0];
  endfunction

  // Offers one item, after random idle cycles, and waits for it to be taken.
  task automatic send_item(input logic [SEC_W-1:0] secs);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    date_check.note_item(secs);
  endtask

  // Holds the input off until every due date has come back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (date_check.pending() != 0) @(posedge clk);
  endtask

  task automatic run_random(input int items, input int s_idle, input int r_idle);
    send_idle = s_idle;
    recv_idle = r_idle;
    repeat (items) send_item(pick_seconds());
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, bit patterns, and leap and century edges.
    send_item('0);
    send_item(1);
    send_item(59);
    send_item(60);
    send_item(3599);
    send_item(3600);
    send_item(86399);
    send_item(86400);
    send_item(MAX_SECONDS);
    send_item(MAX_SECONDS - 1);
    send_item({1'b1, {(SEC_W-1){1'b0}}});
    send_item({1'b0, {(SEC_W-1){1'b1}}});
    send_item(40'h55_5555_5555);
    send_item(40'hAA_AAAA_AAAA);
    send_item(SEC_W'(seconds_at(1973, 1, 1) - 1));
    send_item(SEC_W'(seconds_at(1973, 1, 1)));
    send_item(SEC_W'(seconds_at(2000, 3, 1) - 1));
    send_item(SEC_W'(seconds_at(2000, 3, 1)));
    send_item(SEC_W'(seconds_at(2100, 3, 1) - 1));
    send_item(SEC_W'(seconds_at(2100, 3, 1)));
    send_item(SEC_W'(seconds_at(2400, 2, 29)));
    drain();

    // Random phases with the idle pattern swapped, then at full rate.
    run_random(PHASE_ITEMS, 17, 63);
    run_random(PHASE_ITEMS, 63, 17);
    run_random(PHASE_ITEMS, 0, 0);

    // Catch any stray result after the last one due.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (date_check.mismatches == 0 && date_check.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
